@@ hdl/qlw_pkg.sv @@
// ============================================================================
// qlw_pkg: shared types and constants of the quadtree LOD leaf walk
// Holds the walk sequencer state type, the partial product codes of the
// shared squaring multiplier, the configuration register map and the reset
// values of the configuration registers.
// ============================================================================
package qlw_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Field widths fixed by the interface.
  localparam int unsigned XY_W     = 32;
  localparam int unsigned LOG2_W   = 5;
  localparam int unsigned LVL_W    = 4;
  localparam int unsigned CODE_W   = 32;
  localparam int unsigned QUAD_W   = 2;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned MINSZ_W  = 31;

  // Largest legal root size, and the Q8.8 fraction of the gain.
  localparam logic [LOG2_W-1:0] MAX_ROOT_LOG2 = 5'd30;
  localparam int unsigned       GAIN_FRAC     = 8;

  // Six partial products per node: low, cross and high part of each axis.
  localparam logic [2:0] LAST_PP_STEP = 3'd6;

  // Configuration register map.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROOT_X     = 3'd0,
    CFG_ROOT_Y     = 3'd1,
    CFG_ROOT_LOG2  = 3'd2,
    CFG_MIN_SPLIT  = 3'd3,
    CFG_MAX_LEVELS = 3'd4,
    CFG_GAIN       = 3'd5,
    CFG_ROOT_CODE  = 3'd6
  } cfg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [XY_W-1:0]    RST_ROOT_X     = 32'd0;
  localparam logic [XY_W-1:0]    RST_ROOT_Y     = 32'd0;
  localparam logic [LOG2_W-1:0]  RST_ROOT_LOG2  = 5'd16;
  localparam logic [MINSZ_W-1:0] RST_MIN_SPLIT  = 31'd1024;
  localparam logic [LVL_W-1:0]   RST_MAX_LEVELS = 4'd6;
  localparam logic [GAIN_W-1:0]  RST_GAIN       = 16'd512;
  localparam logic [CODE_W-1:0]  RST_ROOT_CODE  = 32'd0;

  // Quadrant codes in walk order.
  localparam logic [QUAD_W-1:0] QUAD_NW = 2'd0;
  localparam logic [QUAD_W-1:0] QUAD_SW = 2'd3;

  // Which partial product of a square the shared multiplier forms.
  typedef enum logic [1:0] {
    PP_LL,
    PP_HL,
    PP_HH
  } pp_e;

  // Walk sequencer.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GSQ,
    ST_NODE,
    ST_MUL,
    ST_CMP,
    ST_LEAF,
    ST_POP
  } walk_state_e;

endpackage

@@ hdl/quadtree_lod_leaf_walk_unit.sv @@
// ============================================================================
// quadtree_lod_leaf_walk_unit: distance driven quadtree level-of-detail walk
// Takes one viewer position per input beat and walks a square quadtree depth
// first, emitting one output beat per unsplit node (leaf) in walk order.
// ============================================================================
// Sequence: the gain is squared first; a node that gets the distance test then
//   passes through setup, the multiply-accumulate steps and a compare, a
//   node that fails the size or depth test goes straight to its leaf, and
//   every leaf is registered and then climbs level by level to the next sibling.
// Throughput: one viewer position at a time; the shared 17x17 multiplier
//   (for 32 bit coordinates) sets the per node cost.
// Reset: asynchronous, active low; the unit comes up idle with no output beat
//   pending and all configuration registers at their documented defaults.
// ============================================================================
module quadtree_lod_leaf_walk_unit #(
  parameter int unsigned MAX_LEVELS = 15,
  parameter int unsigned MAX_LEAVES = 64,
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [qlw_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [qlw_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,

  // Viewer position channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [qlw_pkg::XY_W-1:0]     viewer_x_i,
  input  logic signed [qlw_pkg::XY_W-1:0]     viewer_y_i,

  // Leaf channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [qlw_pkg::XY_W-1:0]     leaf_x_o,
  output logic signed [qlw_pkg::XY_W-1:0]     leaf_y_o,
  output logic [qlw_pkg::LOG2_W-1:0]          leaf_size_log2_o,
  output logic [qlw_pkg::LVL_W-1:0]           leaf_level_o,
  output logic [qlw_pkg::CODE_W-1:0]          leaf_code_o,
  output logic [qlw_pkg::QUAD_W-1:0]          leaf_quadrant_o,
  output logic                                truncated_o,
  output logic                                last_o
);

  import qlw_pkg::*;

  // Distance magnitudes need one bit beyond the wider of viewer and center.
  localparam int unsigned MW     = ((COORD_BITS > XY_W) ? COORD_BITS : XY_W) + 1;
  // Each magnitude is squared as two halves through one HW x HW multiplier.
  localparam int unsigned HW     = (MW + 1) / 2;
  localparam int unsigned PW     = 2 * HW;
  // Sum of two squares.
  localparam int unsigned ACC_W  = 2 * MW + 1;
  // The compare scales the left side by 2^16 and the right side by 2^(2s).
  localparam int unsigned LHS_W  = ACC_W + 2 * GAIN_FRAC;
  localparam int unsigned RHS_W  = 32 + 2 * 30;
  localparam int unsigned CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int unsigned IDX_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned LC_W   = $clog2(MAX_LEAVES + 1);

  localparam logic [LVL_W-1:0] LVL_CAP  = LVL_W'(MAX_LEVELS);
  localparam logic [LC_W-1:0]  LEAF_CAP = LC_W'(MAX_LEAVES);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [XY_W-1:0]    root_x_q;
  logic [XY_W-1:0]    root_y_q;
  logic [LOG2_W-1:0]  root_log2_q;
  logic [MINSZ_W-1:0] min_split_q;
  logic [LVL_W-1:0]   max_levels_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [CODE_W-1:0]  root_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_x_q     <= RST_ROOT_X;
      root_y_q     <= RST_ROOT_Y;
      root_log2_q  <= RST_ROOT_LOG2;
      min_split_q  <= RST_MIN_SPLIT;
      max_levels_q <= RST_MAX_LEVELS;
      gain_q       <= RST_GAIN;
      root_code_q  <= RST_ROOT_CODE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ROOT_X:     root_x_q     <= cfg_wdata_i[XY_W-1:0];
        CFG_ROOT_Y:     root_y_q     <= cfg_wdata_i[XY_W-1:0];
        CFG_ROOT_LOG2:  root_log2_q  <= cfg_wdata_i[LOG2_W-1:0];
        CFG_MIN_SPLIT:  min_split_q  <= cfg_wdata_i[MINSZ_W-1:0];
        CFG_MAX_LEVELS: max_levels_q <= cfg_wdata_i[LVL_W-1:0];
        CFG_GAIN:       gain_q       <= cfg_wdata_i[GAIN_W-1:0];
        CFG_ROOT_CODE:  root_code_q  <= cfg_wdata_i[CODE_W-1:0];
        default: ;  // Writes past the register map are dropped.
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Walk state
  // --------------------------------------------------------------------------
  walk_state_e state_q, state_d;

  logic signed [XY_W-1:0] vx_q, vy_q;          // viewer of the current walk
  logic [COORD_BITS-1:0]  center_x_q, center_y_q;
  logic [LVL_W-1:0]       level_q;
  logic [CODE_W-1:0]      code_q;
  logic [LC_W-1:0]        cnt_q;               // leaves emitted in this walk
  logic [31:0]            gsq_q;               // gain squared, Q16.16

  // Per depth: quadrant being walked, and the parent center and code.
  logic [QUAD_W-1:0]      stack_q  [MAX_LEVELS];
  logic [COORD_BITS-1:0]  up_x_q   [MAX_LEVELS];
  logic [COORD_BITS-1:0]  up_y_q   [MAX_LEVELS];
  logic [CODE_W-1:0]      up_code_q[MAX_LEVELS];

  // Distance test datapath.
  logic [MW-1:0]          mag_x_q, mag_y_q;
  logic [CMP_W-1:0]       rhs_q;
  logic [ACC_W-1:0]       acc_q;
  logic [PW-1:0]          prod_q;
  pp_e                    part_q;
  logic [2:0]             step_q;

  // Output beat registers.
  logic                   out_valid_q;
  logic [COORD_BITS-1:0]  out_x_q, out_y_q;
  logic [LOG2_W-1:0]      out_log2_q;
  logic [LVL_W-1:0]       out_level_q;
  logic [CODE_W-1:0]      out_code_q;
  logic [QUAD_W-1:0]      out_quad_q;
  logic                   out_trunc_q, out_last_q;

  // --------------------------------------------------------------------------
  // Node geometry and the cheap split conditions
  // --------------------------------------------------------------------------
  logic [LOG2_W-1:0] s0_c, s_c;
  logic [LVL_W-1:0]  lim_c, lvl_m1_c;
  logic [IDX_W-1:0]  cur_idx_c, up_idx_c;
  logic              node_test_c;

  assign s0_c      = (root_log2_q > MAX_ROOT_LOG2) ? MAX_ROOT_LOG2 : root_log2_q;
  assign s_c       = s0_c - LOG2_W'(level_q);
  assign lim_c     = (max_levels_q < LVL_CAP) ? max_levels_q : LVL_CAP;
  assign lvl_m1_c  = level_q - LVL_W'(1);
  assign cur_idx_c = level_q[IDX_W-1:0];
  assign up_idx_c  = lvl_m1_c[IDX_W-1:0];

  // A node below size 4 would put child centers off the integer grid, so it
  // never splits; neither does one at the depth limit or below min size.
  assign node_test_c = (s_c >= LOG2_W'(2)) && (level_q < lim_c) &&
                       !((MINSZ_W'(1) << s_c) < min_split_q);

  // --------------------------------------------------------------------------
  // Shared multiplier
  // Squares each distance magnitude as (H*2^HW + L)^2 = L*L + 2*H*L*2^HW +
  // H*H*2^(2*HW), one partial product per cycle, and squares the gain once
  // at the start of each walk.
  // --------------------------------------------------------------------------
  logic [MW-1:0]     mag_sel_c;
  logic [HW-1:0]     mag_lo_c, mag_hi_c;
  logic [HW-1:0]     mul_a_c, mul_b_c;
  logic [PW-1:0]     mul_p_c;
  pp_e               pp_sel_c;
  logic              y_axis_c;

  always_comb begin
    unique case (step_q)
      3'd0:    begin pp_sel_c = PP_LL; y_axis_c = 1'b0; end
      3'd1:    begin pp_sel_c = PP_HL; y_axis_c = 1'b0; end
      3'd2:    begin pp_sel_c = PP_HH; y_axis_c = 1'b0; end
      3'd3:    begin pp_sel_c = PP_LL; y_axis_c = 1'b1; end
      3'd4:    begin pp_sel_c = PP_HL; y_axis_c = 1'b1; end
      3'd5:    begin pp_sel_c = PP_HH; y_axis_c = 1'b1; end
      default: begin pp_sel_c = PP_LL; y_axis_c = 1'b0; end
    endcase
  end

  assign mag_sel_c = y_axis_c ? mag_y_q : mag_x_q;
  assign mag_lo_c  = mag_sel_c[HW-1:0];
  assign mag_hi_c  = HW'(mag_sel_c >> HW);

  always_comb begin
    if (state_q == ST_GSQ) begin
      mul_a_c = HW'(gain_q);
      mul_b_c = HW'(gain_q);
    end else begin
      mul_a_c = (pp_sel_c == PP_LL) ? mag_lo_c : mag_hi_c;
      mul_b_c = (pp_sel_c == PP_HH) ? mag_hi_c : mag_lo_c;
    end
  end

  assign mul_p_c = PW'(mul_a_c) * PW'(mul_b_c);

  // Weight of the partial product registered last cycle.
  logic [ACC_W-1:0] pp_ext_c, addend_c;

  assign pp_ext_c = ACC_W'(prod_q);

  always_comb begin
    case (part_q)
      PP_HL:   addend_c = pp_ext_c << (HW + 1);
      PP_HH:   addend_c = pp_ext_c << (2 * HW);
      default: addend_c = pp_ext_c;
    endcase
  end

  // Magnitudes of the viewer offset from the node center.
  logic signed [MW-1:0] diff_x_c, diff_y_c;
  logic [MW-1:0]        abs_x_c, abs_y_c;

  assign diff_x_c = MW'(vx_q) - MW'($signed(center_x_q));
  assign diff_y_c = MW'(vy_q) - MW'($signed(center_y_q));
  assign abs_x_c  = diff_x_c[MW-1] ? $unsigned(-diff_x_c) : $unsigned(diff_x_c);
  assign abs_y_c  = diff_y_c[MW-1] ? $unsigned(-diff_y_c) : $unsigned(diff_y_c);

  // Split when (256*dx)^2 + (256*dy)^2 < (2^s * g)^2, i.e. when
  // (dx^2 + dy^2) * 2^16 < g^2 * 2^(2s).
  logic split_c;
  assign split_c = (CMP_W'(acc_q) << (2 * GAIN_FRAC)) < rhs_q;

  // --------------------------------------------------------------------------
  // Child entry
  // Entered either right after a split (first child, NW, of this node) or
  // after a leaf, where the next sibling at the current depth follows.
  // --------------------------------------------------------------------------
  logic                  from_pop_c;
  logic [COORD_BITS-1:0] base_x_c, base_y_c, qtr_c, child_x_c, child_y_c;
  logic [CODE_W-1:0]     base_code_c, child_code_c;
  logic [QUAD_W-1:0]     child_q_c;
  logic [LOG2_W-1:0]     qtr_sh_c;

  assign from_pop_c  = (state_q == ST_POP);
  assign base_x_c    = from_pop_c ? up_x_q[up_idx_c]    : center_x_q;
  assign base_y_c    = from_pop_c ? up_y_q[up_idx_c]    : center_y_q;
  assign base_code_c = from_pop_c ? up_code_q[up_idx_c] : code_q;
  assign child_q_c   = from_pop_c ? (stack_q[up_idx_c] + QUAD_W'(1)) : QUAD_NW;
  // Quarter of the parent edge: parent size is s here after a split, and
  // s + 1 for a sibling at the current depth.
  assign qtr_sh_c    = from_pop_c ? (s_c - LOG2_W'(1)) : (s_c - LOG2_W'(2));
  assign qtr_c       = {{(COORD_BITS-1){1'b0}}, 1'b1} << qtr_sh_c;

  // East children (NE, SE) step +x; north children (NW, NE) step +y.
  assign child_x_c    = (child_q_c[0] ^ child_q_c[1]) ? (base_x_c + qtr_c)
                                                      : (base_x_c - qtr_c);
  assign child_y_c    = !child_q_c[1] ? (base_y_c + qtr_c) : (base_y_c - qtr_c);
  assign child_code_c = {base_code_c[CODE_W-3:0], child_q_c};

  // --------------------------------------------------------------------------
  // Leaf bookkeeping
  // --------------------------------------------------------------------------
  logic out_free_c, pop_c, more_c, lim_hit_c;
  logic [LC_W-1:0] cnt_inc_c;

  assign out_free_c = !out_valid_q || !out_stall_i;
  // Climb while the node at this depth was the last (SW) child.
  assign pop_c      = (level_q != '0) && (stack_q[up_idx_c] == QUAD_SW);
  assign more_c     = (level_q != '0);
  assign cnt_inc_c  = cnt_q + LC_W'(1);
  assign lim_hit_c  = (cnt_inc_c == LEAF_CAP);

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_GSQ;
      ST_GSQ:  state_d = ST_NODE;
      ST_NODE: state_d = node_test_c ? ST_MUL : ST_LEAF;
      ST_MUL:  if (step_q == LAST_PP_STEP) state_d = ST_CMP;
      ST_CMP:  state_d = split_c ? ST_NODE : ST_LEAF;
      ST_LEAF: if (out_free_c) state_d = ST_POP;
      ST_POP: begin
        if (pop_c) begin
          state_d = ST_POP;
        end else if (more_c && !lim_hit_c) begin
          state_d = ST_NODE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: control outputs
  // --------------------------------------------------------------------------
  logic ld_item, ld_gsq, ld_node, mul_run, push_split, ld_leaf;
  logic pop_lvl, emit, descend_next, stall_c;

  always_comb begin
    ld_item      = 1'b0;
    ld_gsq       = 1'b0;
    ld_node      = 1'b0;
    mul_run      = 1'b0;
    push_split   = 1'b0;
    ld_leaf      = 1'b0;
    pop_lvl      = 1'b0;
    emit         = 1'b0;
    descend_next = 1'b0;
    stall_c      = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        stall_c = 1'b0;
        ld_item = in_valid_i;
      end
      ST_GSQ:  ld_gsq     = 1'b1;
      ST_NODE: ld_node    = node_test_c;
      ST_MUL:  mul_run    = 1'b1;
      ST_CMP:  push_split = split_c;
      ST_LEAF: ld_leaf    = out_free_c;
      ST_POP: begin
        pop_lvl      = pop_c;
        emit         = !pop_c;
        descend_next = !pop_c && more_c && !lim_hit_c;
      end
      default: ;
    endcase
  end

  assign in_stall_o = stall_c;

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      level_q     <= '0;
      cnt_q       <= '0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;

      // A new beat is only raised after the previous one has gone.
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (ld_item) begin
        level_q <= '0;
      end else if (push_split) begin
        level_q <= level_q + LVL_W'(1);
      end else if (pop_lvl) begin
        level_q <= lvl_m1_c;
      end

      if (ld_item) begin
        cnt_q <= '0;
      end else if (emit) begin
        cnt_q <= cnt_inc_c;
      end

      if (ld_node) begin
        step_q <= '0;
      end else if (mul_run) begin
        step_q <= step_q + 3'd1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (ld_item) begin
      vx_q       <= viewer_x_i;
      vy_q       <= viewer_y_i;
      center_x_q <= COORD_BITS'($signed(root_x_q));
      center_y_q <= COORD_BITS'($signed(root_y_q));
      code_q     <= root_code_q;
    end else if (push_split || descend_next) begin
      center_x_q <= child_x_c;
      center_y_q <= child_y_c;
      code_q     <= child_code_c;
    end

    if (ld_gsq) begin
      gsq_q <= mul_p_c[31:0];
    end

    if (ld_node) begin
      mag_x_q <= abs_x_c;
      mag_y_q <= abs_y_c;
      rhs_q   <= CMP_W'(gsq_q) << {s_c, 1'b0};
      acc_q   <= '0;
    end else if (mul_run) begin
      if (step_q != LAST_PP_STEP) begin
        prod_q <= mul_p_c;
        part_q <= pp_sel_c;
      end
      if (step_q != 3'd0) begin
        acc_q <= acc_q + addend_c;
      end
    end

    // Parent record and quadrant stack: one write per cycle at most.
    if (push_split) begin
      up_x_q[cur_idx_c]    <= center_x_q;
      up_y_q[cur_idx_c]    <= center_y_q;
      up_code_q[cur_idx_c] <= code_q;
      stack_q[cur_idx_c]   <= QUAD_NW;
    end else if (descend_next) begin
      stack_q[up_idx_c]    <= child_q_c;
    end

    if (ld_leaf) begin
      out_x_q     <= center_x_q;
      out_y_q     <= center_y_q;
      out_log2_q  <= s_c;
      out_level_q <= level_q;
      out_code_q  <= code_q;
      out_quad_q  <= more_c ? stack_q[up_idx_c] : QUAD_NW;
    end

    // Last and truncated are known only once the climb has finished.
    if (emit) begin
      out_last_q  <= !more_c || lim_hit_c;
      out_trunc_q <= more_c && lim_hit_c;
    end
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign out_valid_o      = out_valid_q;
  assign leaf_x_o         = XY_W'($signed(out_x_q));
  assign leaf_y_o         = XY_W'($signed(out_y_q));
  assign leaf_size_log2_o = out_log2_q;
  assign leaf_level_o     = out_level_q;
  assign leaf_code_o      = out_code_q;
  assign leaf_quadrant_o  = out_quad_q;
  assign truncated_o      = out_trunc_q;
  assign last_o           = out_last_q;

endmodule

@@ hdl/qlw_checker.sv @@
// ============================================================================
// qlw_checker: port level checks for the quadtree LOD leaf walk
// Watches the viewer and leaf channels of the top level and is attached to
// it by the bind statement at the end of this file.
// ============================================================================
module qlw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] leaf_x_o,
  input logic [31:0]        leaf_code_o,
  input logic [3:0]         leaf_level_o,
  input logic [1:0]         leaf_quadrant_o,
  input logic               truncated_o,
  input logic               last_o
);

  // A stalled leaf beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(leaf_x_o) &&
                                   $stable(leaf_code_o) && $stable(last_o))
    else $error("stalled leaf beat changed or dropped");

  // A truncated walk always ends on that beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && truncated_o |-> last_o)
    else $error("truncated leaf not flagged as last");

  // The root leaf has no parent quadrant and is the last beat of its walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (leaf_level_o == 4'd0) |-> (leaf_quadrant_o == 2'd0) && last_o)
    else $error("root leaf with nonzero quadrant or not last");

  // Once a viewer beat is taken, the walk keeps the input stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("viewer input accepted during a walk");

endmodule

bind quadtree_lod_leaf_walk_unit qlw_checker u_qlw_checker (.*);
